@@ src/dctb_pkg.sv @@
// shared types, constants and arithmetic helpers for the 8x8 dct block transform
// no dependencies; imported by every module of the block except dctb_ram
package dctb_pkg;

    // block geometry
    localparam int DIM      = 8;
    localparam int LG_DIM   = 3;
    localparam int NSAMP    = DIM * DIM;
    localparam int LG_NSAMP = 6;

    // number formats
    localparam int SAMPLE_W       = 19;
    localparam int PASS_W         = 24;
    localparam int COEF_W         = 15;
    localparam int COEF_FRAC_BITS = 14;
    localparam int PASS_FRAC_BITS = 2;
    localparam int PROD_W         = 39;
    localparam int ACC_W          = 42;
    localparam int EXT_W          = ACC_W + 1;
    localparam int TDATA_W        = 24;

    localparam int ROW_SHIFT = COEF_FRAC_BITS - PASS_FRAC_BITS;
    localparam int COL_SHIFT = COEF_FRAC_BITS + PASS_FRAC_BITS;

    localparam logic signed [EXT_W-1:0] ROW_HALF = EXT_W'(2 ** (ROW_SHIFT - 1));
    localparam logic signed [EXT_W-1:0] COL_HALF = EXT_W'(2 ** (COL_SHIFT - 1));
    localparam logic signed [EXT_W-1:0] PASS_MAX = EXT_W'(2 ** (PASS_W - 1) - 1);
    localparam logic signed [EXT_W-1:0] PASS_MIN = -EXT_W'(2 ** (PASS_W - 1));
    localparam logic signed [EXT_W-1:0] RES_MAX  = EXT_W'(2 ** (SAMPLE_W - 1) - 1);
    localparam logic signed [EXT_W-1:0] RES_MIN  = -EXT_W'(2 ** (SAMPLE_W - 1));

    typedef logic [LG_DIM-1:0] idx_t;

    // one queued block job: which sample bank, which direction
    typedef struct packed {
        logic bank;
        logic mode;
    } job_t;

    // dc row scale, 1/sqrt(8) in q1.14
    localparam logic signed [COEF_W-1:0] DC_COEF = 15'sd5793;

    // 0.5*cos(pi*a/16) in q1.14 for the first quadrant, a = 0..8
    localparam logic signed [COEF_W-1:0] COS_TAB [DIM+1] = '{
        15'sd8192, 15'sd8035, 15'sd7568, 15'sd6811, 15'sd5793,
        15'sd4551, 15'sd3135, 15'sd1598, 15'sd0
    };

    // orthonormal dct-ii matrix entry c[u][x]
    function automatic logic signed [COEF_W-1:0] coef(input idx_t u, input idx_t x);
        logic [7:0] prod;
        logic [4:0] m;
        logic signed [COEF_W-1:0] val;
        prod = {4'b0000, x, 1'b1} * {5'b00000, u};
        m    = prod[4:0];
        if (u == '0)
            val = DC_COEF;
        else if (m <= 5'd8)
            val = COS_TAB[m[3:0]];
        else if (m <= 5'd16)
            val = -COS_TAB[4'(5'd16 - m)];
        else if (m <= 5'd24)
            val = -COS_TAB[4'(m - 5'd16)];
        else
            val = COS_TAB[4'(6'd32 - {1'b0, m})];
        return val;
    endfunction

    // row pass: round half away from zero, saturate to the intermediate width
    function automatic logic signed [PASS_W-1:0] round_row(input logic signed [ACC_W-1:0] v);
        logic signed [EXT_W-1:0] w;
        logic signed [EXT_W-1:0] r;
        w = EXT_W'(v);
        if (!v[ACC_W-1])
            r = (w + ROW_HALF) >>> ROW_SHIFT;
        else
            r = -((-w + ROW_HALF) >>> ROW_SHIFT);
        if (r > PASS_MAX)
            r = PASS_MAX;
        else if (r < PASS_MIN)
            r = PASS_MIN;
        return r[PASS_W-1:0];
    endfunction

    // column pass: round half away from zero, saturate to the result width
    function automatic logic signed [SAMPLE_W-1:0] round_col(input logic signed [ACC_W-1:0] v);
        logic signed [EXT_W-1:0] w;
        logic signed [EXT_W-1:0] r;
        w = EXT_W'(v);
        if (!v[ACC_W-1])
            r = (w + COL_HALF) >>> COL_SHIFT;
        else
            r = -((-w + COL_HALF) >>> COL_SHIFT);
        if (r > RES_MAX)
            r = RES_MAX;
        else if (r < RES_MIN)
            r = RES_MIN;
        return r[SAMPLE_W-1:0];
    endfunction

endpackage

@@ src/dctb_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module dctb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/dctb_front.sv @@
// front end: takes samples, fills one of two sample banks, queues a job per full block
// depends on dctb_pkg
module dctb_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic signed [dctb_pkg::SAMPLE_W-1:0] sample_value,
    input  logic                                 inverse_mode,
    input  logic                                 rel_valid,
    input  logic                                 rel_bank,
    output logic                                 blk_we,
    output logic [dctb_pkg::LG_NSAMP:0]          blk_waddr,
    output logic [dctb_pkg::SAMPLE_W-1:0]        blk_wdata,
    output logic                                 push,
    output dctb_pkg::job_t                       push_job
);
    import dctb_pkg::*;

    logic                bank_reg, bank_next;
    logic [LG_NSAMP-1:0] cnt_reg, cnt_next;
    logic [1:0]          busy_reg, busy_next;
    logic                accept;

    // a bank is refilled only once the back end has read it out
    assign s_tready = !busy_reg[bank_reg];
    assign accept   = s_tvalid && s_tready;

    assign blk_we    = accept;
    assign blk_waddr = {bank_reg, cnt_reg};
    assign blk_wdata = sample_value;

    assign push          = accept && (cnt_reg == LG_NSAMP'(NSAMP - 1));
    assign push_job.bank = bank_reg;
    assign push_job.mode = inverse_mode;

    // fill counter, bank select and busy flags
    always_comb
    begin
        cnt_next  = cnt_reg;
        bank_next = bank_reg;
        busy_next = busy_reg;
        if (accept)
            cnt_next = cnt_reg + 1'b1;
        if (rel_valid)
            busy_next[rel_bank] = 1'b0;
        if (push)
        begin
            busy_next[bank_reg] = 1'b1;
            bank_next           = !bank_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            bank_reg <= 1'b0;
            busy_reg <= '0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            bank_reg <= bank_next;
            busy_reg <= busy_next;
        end
    end

endmodule

@@ src/dctb_queue.sv @@
// two-entry job queue between front and back end
// depends on dctb_pkg
module dctb_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  dctb_pkg::job_t push_job,
    input  logic           pop,
    output logic           not_empty,
    output dctb_pkg::job_t head
);
    import dctb_pkg::*;

    job_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg, cnt_next;

    assign not_empty = (cnt_reg != 2'd0);
    assign head      = mem_reg[rp_reg];

    // occupancy
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= !wp_reg;
            if (pop)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_job;
    end

endmodule

@@ src/dctb_back.sv @@
// back end: row pass and column pass on eight mac lanes, row buffer and output register
// depends on dctb_pkg and dctb_ram
module dctb_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 job_valid,
    input  dctb_pkg::job_t                       job_head,
    output logic                                 job_pop,
    output logic [dctb_pkg::LG_NSAMP:0]          blk_raddr,
    input  logic signed [dctb_pkg::SAMPLE_W-1:0] blk_rdata,
    output logic                                 rel_valid,
    output logic                                 rel_bank,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output logic [dctb_pkg::SAMPLE_W-1:0]        res_value,
    output logic                                 res_last
);
    import dctb_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE      = 5'b00001,
        ST_ROW       = 5'b00010,
        ST_ROW_DRAIN = 5'b00100,
        ST_COL       = 5'b01000,
        ST_COL_DRAIN = 5'b10000
    } back_state_t;

    localparam idx_t       LAST_IDX = idx_t'(DIM - 1);
    localparam logic [1:0] ROWS_MAX = 2'd2;

    back_state_t state_reg, state_next;
    job_t        job_reg;
    idx_t        i_reg, i_next, k_reg, k_next;
    logic        issue, row_start, pipe_empty;

    // pipeline tags
    logic s1_v_reg, s1_first_reg, s1_last_reg, s1_col_reg;
    idx_t s1_row_reg, s1_k_reg;
    logic s2_v_reg, s2_first_reg, s2_last_reg, s2_col_reg;
    idx_t s2_row_reg;
    logic done_v_reg, done_col_reg;
    idx_t done_row_reg;

    // lanes
    logic signed [PROD_W-1:0] prod_next [DIM];
    logic signed [PROD_W-1:0] prod_reg  [DIM];
    logic signed [ACC_W-1:0]  acc_reg   [DIM];

    // intermediate store
    logic                     pass_we;
    logic [DIM*PASS_W-1:0]    pass_wdata, pass_rdata;

    // row buffer and output register
    logic signed [SAMPLE_W-1:0] obuf_reg [2][DIM];
    logic [1:0]                 olast_reg;
    logic                       wr_slot_reg, rd_slot_reg;
    logic [1:0]                 ocnt_reg, ocnt_next;
    logic [1:0]                 rows_pend_reg, rows_pend_next;
    idx_t                       e_reg;
    logic                       col_done, out_load, slot_free;
    logic                       m_valid_reg;
    logic [SAMPLE_W-1:0]        m_value_reg;
    logic                       m_last_reg;

    assign pipe_empty = !s1_v_reg && !s2_v_reg && !done_v_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        issue      = 1'b0;
        row_start  = 1'b0;
        job_pop    = 1'b0;
        rel_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop    = 1'b1;
                    i_next     = '0;
                    k_next     = '0;
                    state_next = ST_ROW;
                end
            end
            ST_ROW:
            begin
                issue  = 1'b1;
                k_next = k_reg + 1'b1;
                if (k_reg == LAST_IDX)
                begin
                    i_next = i_reg + 1'b1;
                    if (i_reg == LAST_IDX)
                    begin
                        rel_valid  = 1'b1;
                        state_next = ST_ROW_DRAIN;
                    end
                end
            end
            ST_ROW_DRAIN:
            begin
                if (pipe_empty)
                    state_next = ST_COL;
            end
            ST_COL:
            begin
                if ((k_reg != '0) || (rows_pend_reg != ROWS_MAX))
                begin
                    issue     = 1'b1;
                    row_start = (k_reg == '0);
                    k_next    = k_reg + 1'b1;
                    if (k_reg == LAST_IDX)
                    begin
                        i_next = i_reg + 1'b1;
                        if (i_reg == LAST_IDX)
                            state_next = ST_COL_DRAIN;
                    end
                end
            end
            ST_COL_DRAIN:
            begin
                if (pipe_empty)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rel_bank  = job_reg.bank;
    assign blk_raddr = {job_reg.bank, i_reg, k_reg};

    // intermediate store, one row of lanes per entry
    dctb_ram #(
        .WIDTH (DIM * PASS_W),
        .DEPTH (DIM)
    ) u_pass_ram (
        .clk   (clk),
        .we    (pass_we),
        .waddr (done_row_reg),
        .wdata (pass_wdata),
        .raddr (k_reg),
        .rdata (pass_rdata)
    );

    // operand select and multiply, one lane per column
    for (genvar j = 0; j < DIM; j++)
    begin : g_lane
        logic signed [COEF_W-1:0] c_l;
        logic signed [PASS_W-1:0] a_l;

        always_comb
        begin
            if (s1_col_reg)
            begin
                c_l = job_reg.mode ? coef(s1_k_reg, s1_row_reg) : coef(s1_row_reg, s1_k_reg);
                a_l = $signed(pass_rdata[j*PASS_W +: PASS_W]);
            end
            else
            begin
                c_l = job_reg.mode ? coef(s1_k_reg, idx_t'(j)) : coef(idx_t'(j), s1_k_reg);
                a_l = PASS_W'(blk_rdata);
            end
            prod_next[j] = PROD_W'(a_l) * PROD_W'(c_l);
        end

        assign pass_wdata[j*PASS_W +: PASS_W] = round_row(acc_reg[j]);
    end

    // product and accumulator registers
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < DIM; j++)
        begin
            prod_reg[j] <= prod_next[j];
            if (s2_v_reg)
                acc_reg[j] <= (s2_first_reg ? ACC_W'(0) : acc_reg[j]) + ACC_W'(prod_reg[j]);
        end
    end

    // pipeline tags
    always_ff @(posedge clk)
    begin
        s1_first_reg <= (k_reg == '0);
        s1_last_reg  <= (k_reg == LAST_IDX);
        s1_col_reg   <= (state_reg == ST_COL);
        s1_row_reg   <= i_reg;
        s1_k_reg     <= k_reg;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_col_reg   <= s1_col_reg;
        s2_row_reg   <= s1_row_reg;
        done_col_reg <= s2_col_reg;
        done_row_reg <= s2_row_reg;
        if (job_pop)
            job_reg <= job_head;
    end

    assign pass_we  = done_v_reg && !done_col_reg;
    assign col_done = done_v_reg && done_col_reg;

    // output register fed from the row buffer
    assign out_load  = (ocnt_reg != 2'd0) && (!m_valid_reg || res_ready);
    assign slot_free = out_load && (e_reg == LAST_IDX);

    always_comb
    begin
        ocnt_next      = ocnt_reg;
        rows_pend_next = rows_pend_reg;
        if (col_done && !slot_free)
            ocnt_next = ocnt_reg + 2'd1;
        else if (slot_free && !col_done)
            ocnt_next = ocnt_reg - 2'd1;
        if (row_start && !slot_free)
            rows_pend_next = rows_pend_reg + 2'd1;
        else if (slot_free && !row_start)
            rows_pend_next = rows_pend_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            k_reg         <= '0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            done_v_reg    <= 1'b0;
            wr_slot_reg   <= 1'b0;
            rd_slot_reg   <= 1'b0;
            ocnt_reg      <= 2'd0;
            rows_pend_reg <= 2'd0;
            e_reg         <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            k_reg         <= k_next;
            s1_v_reg      <= issue;
            s2_v_reg      <= s1_v_reg;
            done_v_reg    <= s2_v_reg && s2_last_reg;
            ocnt_reg      <= ocnt_next;
            rows_pend_reg <= rows_pend_next;
            if (col_done)
                wr_slot_reg <= !wr_slot_reg;
            if (out_load)
            begin
                e_reg <= e_reg + 1'b1;
                if (e_reg == LAST_IDX)
                    rd_slot_reg <= !rd_slot_reg;
            end
            if (out_load)
                m_valid_reg <= 1'b1;
            else if (res_ready)
                m_valid_reg <= 1'b0;
        end
    end

    // row buffer and output payload
    always_ff @(posedge clk)
    begin
        if (col_done)
        begin
            for (int j = 0; j < DIM; j++)
                obuf_reg[wr_slot_reg][j] <= round_col(acc_reg[j]);
            olast_reg[wr_slot_reg] <= (done_row_reg == LAST_IDX);
        end
        if (out_load)
        begin
            m_value_reg <= obuf_reg[rd_slot_reg][e_reg];
            m_last_reg  <= olast_reg[rd_slot_reg] && (e_reg == LAST_IDX);
        end
    end

    assign res_valid = m_valid_reg;
    assign res_value = m_value_reg;
    assign res_last  = m_last_reg;

    // a finished column row never lands on a full row buffer
    a_no_buf_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        col_done |-> (ocnt_reg != ROWS_MAX))
        else $error("row buffer overrun");

    // rows in the buffer never exceed rows started, and rows started never exceed two
    a_buf_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (ocnt_reg <= rows_pend_reg) && (rows_pend_reg <= ROWS_MAX))
        else $error("row buffer count out of bounds");

    // the intermediate store is written only during the row pass
    a_pass_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        pass_we |-> ((state_reg == ST_ROW) || (state_reg == ST_ROW_DRAIN)))
        else $error("intermediate store written outside row pass");

    // a new job starts only after the previous one has fully drained
    a_pop_drained: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> pipe_empty)
        else $error("job started with work in flight");

endmodule

@@ src/dct_2d_block_transform.sv @@
// top level of the 8x8 orthonormal 2d dct-ii / inverse dct block transform
// depends on dctb_pkg, dctb_ram, dctb_front, dctb_queue, dctb_back
//
// usage:
//   input stream s_*: one signed 19-bit sample per item, 64 items per block in
//   row-major order. output stream m_*: 64 signed 19-bit results per block in
//   row-major order, m_tlast high on the final result of each block.
//   cfg_wr_en/cfg_wr_data write the direction bit (0 forward, 1 inverse); it is
//   taken for a block when its last sample is accepted.
// operation:
//   samples go in at one per cycle while s_tready is high, into one of two banks.
//   a block's row pass runs on eight multiply-accumulate lanes and then drains,
//   then the column pass produces the results one row of eight at a time. the rate
//   of a steady stream of blocks is set by the mac lanes doing both passes in turn.
// reset:
//   rst_n clears all counters, queue and flags and the direction bit; no clearing
//   pass over the stores is needed.
// stall:
//   a stalled receiver holds m_* steady; once two result rows are started but not
//   yet sent the column pass pauses, and with both sample banks full s_tready drops.
module dct_2d_block_transform (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [18:0] sample_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [18:0] result_value
    output logic        m_tlast    // last_of_block
);
    import dctb_pkg::*;

    logic                inverse_mode_reg;
    logic                blk_we;
    logic [LG_NSAMP:0]   blk_waddr, blk_raddr;
    logic [SAMPLE_W-1:0] blk_wdata, blk_rdata;
    logic                push, pop, q_not_empty;
    job_t                push_job, q_head;
    logic                rel_valid, rel_bank;
    logic [SAMPLE_W-1:0] res_value;

    // direction register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inverse_mode_reg <= 1'b0;
        else if (cfg_wr_en)
            inverse_mode_reg <= cfg_wr_data;
    end

    dctb_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .sample_value ($signed(s_tdata[SAMPLE_W-1:0])),
        .inverse_mode (inverse_mode_reg),
        .rel_valid    (rel_valid),
        .rel_bank     (rel_bank),
        .blk_we       (blk_we),
        .blk_waddr    (blk_waddr),
        .blk_wdata    (blk_wdata),
        .push         (push),
        .push_job     (push_job)
    );

    // two banks of samples
    dctb_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (2 * NSAMP)
    ) u_blk_ram (
        .clk   (clk),
        .we    (blk_we),
        .waddr (blk_waddr),
        .wdata (blk_wdata),
        .raddr (blk_raddr),
        .rdata (blk_rdata)
    );

    dctb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    dctb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_not_empty),
        .job_head  (q_head),
        .job_pop   (pop),
        .blk_raddr (blk_raddr),
        .blk_rdata ($signed(blk_rdata)),
        .rel_valid (rel_valid),
        .rel_bank  (rel_bank),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_value (res_value),
        .res_last  (m_tlast)
    );

    assign m_tdata = {{(TDATA_W - SAMPLE_W){1'b0}}, res_value};

endmodule
